FILE: rtl/mts_pkg.sv
// Shared types, constants and tune ROM contents for the melody tone sequencer.
`timescale 1ns / 1ps
`default_nettype none

package mts_pkg;

    localparam int TuneCount    = 8;
    localparam int NotesPerTune = 8;
    localparam int PitchCount   = 25;

    localparam int TitleW    = $clog2(TuneCount);
    localparam int IndexW    = $clog2(NotesPerTune);
    localparam int LenW      = $clog2(NotesPerTune + 1);
    localparam int PitchIdxW = $clog2(PitchCount);
    localparam int PeriodW   = 12;
    localparam int DurW      = 10;
    localparam int VolW      = 2;

    localparam logic CMD_PLAY    = 1'b0;
    localparam logic CMD_ELAPSED = 1'b1;

    localparam logic [VolW-1:0] VOL_OFF = 2'd0;

    // Pitch index zero is a pause.
    localparam logic [PitchIdxW-1:0] PITCH_PAUSE = '0;

    typedef logic [TitleW-1:0]  title_t;
    typedef logic [IndexW-1:0]  index_t;
    typedef logic [LenW-1:0]    len_t;
    typedef logic [PeriodW-1:0] period_t;
    typedef logic [DurW-1:0]    dur_t;
    typedef logic [VolW-1:0]    vol_t;

    typedef struct packed {
        logic    tone_on;
        period_t period;
        dur_t    duration;
        len_t    length;
    } mts_note_t;

    function automatic period_t pitch_period(input logic [PitchIdxW-1:0] p);
        period_t r;
        begin
            case (p)
                5'd1:    r = 12'd3831;
                5'd2:    r = 12'd3413;
                5'd3:    r = 12'd3039;
                5'd4:    r = 12'd2863;
                5'd5:    r = 12'd2551;
                5'd6:    r = 12'd2272;
                5'd7:    r = 12'd2146;
                5'd8:    r = 12'd2024;
                5'd9:    r = 12'd1912;
                5'd10:   r = 12'd1703;
                5'd11:   r = 12'd1517;
                5'd12:   r = 12'd1432;
                5'd13:   r = 12'd1275;
                5'd14:   r = 12'd1136;
                5'd15:   r = 12'd1013;
                5'd16:   r = 12'd956;
                5'd17:   r = 12'd852;
                5'd18:   r = 12'd758;
                5'd19:   r = 12'd716;
                5'd20:   r = 12'd637;
                5'd21:   r = 12'd568;
                5'd22:   r = 12'd506;
                5'd23:   r = 12'd477;
                5'd24:   r = 12'd426;
                default: r = 12'd16;
            endcase
            return r;
        end
    endfunction

    function automatic len_t tune_len(input title_t t);
        len_t r;
        begin
            case (t)
                3'd1:    r = 4'd8;
                3'd2:    r = 4'd1;
                3'd3:    r = 4'd3;
                3'd4:    r = 4'd1;
                3'd5:    r = 4'd3;
                3'd6:    r = 4'd1;
                3'd7:    r = 4'd5;
                default: r = 4'd0;
            endcase
            return r;
        end
    endfunction

    function automatic logic [PitchIdxW-1:0] tune_pitch(input title_t t, input index_t i);
        logic [PitchIdxW-1:0] r;
        begin
            r = PITCH_PAUSE;
            case (t)
                3'd1:
                begin
                    case (i)
                        3'd0, 3'd2: r = 5'd10;
                        3'd3, 3'd5, 3'd7: r = 5'd7;
                        default: r = PITCH_PAUSE;
                    endcase
                end
                3'd2, 3'd4:
                begin
                    if (i == 3'd0)
                        r = 5'd21;
                end
                3'd3:
                begin
                    if (i == 3'd0 || i == 3'd2)
                        r = 5'd21;
                end
                3'd5:
                begin
                    case (i)
                        3'd0:    r = 5'd14;
                        3'd1:    r = 5'd16;
                        3'd2:    r = 5'd18;
                        default: r = PITCH_PAUSE;
                    endcase
                end
                3'd6:
                begin
                    if (i == 3'd0)
                        r = 5'd24;
                end
                3'd7:
                begin
                    if (i == 3'd0 || i == 3'd2 || i == 3'd4)
                        r = 5'd14;
                end
                default: r = PITCH_PAUSE;
            endcase
            return r;
        end
    endfunction

    function automatic dur_t tune_dur(input title_t t, input index_t i);
        dur_t r;
        begin
            r = '0;
            case (t)
                3'd0:
                begin
                    if (i == 3'd0)
                        r = 10'd10;
                end
                3'd1:
                begin
                    case (i)
                        3'd0, 3'd3, 3'd5: r = 10'd260;
                        3'd1, 3'd4, 3'd6: r = 10'd20;
                        default:          r = 10'd520;
                    endcase
                end
                3'd2:
                begin
                    if (i == 3'd0)
                        r = 10'd120;
                end
                3'd3:
                begin
                    case (i)
                        3'd0, 3'd2: r = 10'd60;
                        3'd1:       r = 10'd20;
                        default:    r = '0;
                    endcase
                end
                3'd4:
                begin
                    if (i == 3'd0)
                        r = 10'd300;
                end
                3'd5:
                begin
                    case (i)
                        3'd0:    r = 10'd200;
                        3'd1:    r = 10'd100;
                        3'd2:    r = 10'd75;
                        default: r = '0;
                    endcase
                end
                3'd6:
                begin
                    if (i == 3'd0)
                        r = 10'd25;
                end
                default:
                begin
                    case (i)
                        3'd0, 3'd2, 3'd4: r = 10'd350;
                        3'd1, 3'd3:       r = 10'd100;
                        default:          r = '0;
                    endcase
                end
            endcase
            return r;
        end
    endfunction

endpackage

`default_nettype wire

FILE: rtl/mts_if.sv
// Valid/ready channel interfaces for sequencer requests and results.
`timescale 1ns / 1ps
`default_nettype none

interface mts_req_if;
    logic       valid;
    logic       ready;
    logic       cmd;
    logic [2:0] title;

    modport source (output valid, output cmd, output title, input ready);
    modport sink (input valid, input cmd, input title, output ready);
endinterface

interface mts_rsp_if;
    logic        valid;
    logic        ready;
    logic        started;
    logic        playing;
    logic        tone_on;
    logic [11:0] pitch_period_us;
    logic [9:0]  note_duration_ms;
    logic        finished;

    modport source (output valid, output started, output playing, output tone_on,
                    output pitch_period_us, output note_duration_ms, output finished,
                    input ready);
    modport sink (input valid, input started, input playing, input tone_on,
                  input pitch_period_us, input note_duration_ms, input finished,
                  output ready);
endinterface

`default_nettype wire

FILE: rtl/mts_rom.sv
// Tune ROM lookup: note period, duration, tone flag and tune length.
`timescale 1ns / 1ps
`default_nettype none

module mts_rom (
    input  wire mts_pkg::title_t title,
    input  wire mts_pkg::index_t index,
    output mts_pkg::mts_note_t   note
);
    import mts_pkg::*;

    logic [PitchIdxW-1:0] pitch;

    always_comb
    begin
        pitch         = tune_pitch(title, index);
        note.tone_on  = (pitch != PITCH_PAUSE);
        note.period   = pitch_period(pitch);
        note.duration = tune_dur(title, index);
        note.length   = tune_len(title);
    end

endmodule

`default_nettype wire

FILE: rtl/melody_tone_sequencer_top.sv
// Top level of the melody tone sequencer: state, handshakes and result register.
// Usage:
//   cfg_we/cfg_wdata set the volume level; zero blocks new play requests.
//   Write it only while no request is outstanding.
//   Each request on "item" is either a play request (cmd 0, with a title)
//   or a note-elapsed event (cmd 1). Every request yields one result on
//   "result" carrying started, playing, tone_on, the current note period and
//   duration, and finished.
//   Latency: the result is valid the cycle after the request is accepted.
//   Throughput: one request per cycle unless the receiver stalls; the next
//   state and the note lookup are one short combinational pass from the
//   state registers into the result register.
//   item.ready stays high while the result register is empty or being
//   taken; when the receiver stalls, the result holds and item.ready drops
//   until the result is taken.
//   Reset clears the volume, the playback state and the result valid flag;
//   the block comes up idle and silent.
`timescale 1ns / 1ps
`default_nettype none

module melody_tone_sequencer_top (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          cfg_we,
    input  wire mts_pkg::vol_t cfg_wdata,
    mts_req_if.sink            item,
    mts_rsp_if.source          result
);
    import mts_pkg::*;

    vol_t      volume_reg;
    title_t    active_reg, active_next;
    index_t    index_reg, index_next;
    period_t   period_reg, period_next;
    dur_t      dur_reg, dur_next;
    logic      tone_reg, tone_next;
    logic      started_next, finished_next;

    logic      rsp_valid_reg;
    logic      rsp_started_reg, rsp_playing_reg, rsp_tone_reg, rsp_finished_reg;
    period_t   rsp_period_reg;
    dur_t      rsp_dur_reg;

    logic      accept;
    logic      idle;
    logic [LenW-1:0] next_pos;
    title_t    rom_title;
    index_t    rom_index;
    mts_note_t rom_note;

    assign item.ready = !rsp_valid_reg || result.ready;
    assign accept     = item.valid && item.ready;
    assign idle       = (active_reg == '0);
    assign next_pos   = LenW'(index_reg) + LenW'(1);

    // Look up the new title while idle, otherwise the following note.
    assign rom_title = idle ? item.title : active_reg;
    assign rom_index = idle ? '0 : next_pos[IndexW-1:0];

    mts_rom u_rom (
        .title (rom_title),
        .index (rom_index),
        .note  (rom_note)
    );

    always_comb
    begin
        active_next   = active_reg;
        index_next    = index_reg;
        period_next   = period_reg;
        dur_next      = dur_reg;
        tone_next     = tone_reg;
        started_next  = 1'b0;
        finished_next = 1'b0;
        if (item.cmd == CMD_PLAY)
        begin
            if (volume_reg != VOL_OFF && idle && item.title != '0 &&
                rom_note.length != '0)
            begin
                active_next  = item.title;
                index_next   = '0;
                period_next  = rom_note.period;
                dur_next     = rom_note.duration;
                tone_next    = rom_note.tone_on;
                started_next = 1'b1;
            end
        end
        else if (!idle)
        begin
            if (next_pos < rom_note.length)
            begin
                index_next  = next_pos[IndexW-1:0];
                period_next = rom_note.period;
                dur_next    = rom_note.duration;
                tone_next   = rom_note.tone_on;
            end
            else
            begin
                // Drop back to idle after the last note.
                active_next   = '0;
                index_next    = '0;
                period_next   = '0;
                dur_next      = '0;
                tone_next     = 1'b0;
                finished_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            volume_reg    <= VOL_OFF;
            active_reg    <= '0;
            index_reg     <= '0;
            period_reg    <= '0;
            dur_reg       <= '0;
            tone_reg      <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
                volume_reg <= cfg_wdata;
            if (accept)
            begin
                active_reg <= active_next;
                index_reg  <= index_next;
                period_reg <= period_next;
                dur_reg    <= dur_next;
                tone_reg   <= tone_next;
            end
            if (accept)
                rsp_valid_reg <= 1'b1;
            else if (result.ready)
                rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            rsp_started_reg  <= started_next;
            rsp_playing_reg  <= (active_next != '0);
            rsp_tone_reg     <= tone_next;
            rsp_period_reg   <= period_next;
            rsp_dur_reg      <= dur_next;
            rsp_finished_reg <= finished_next;
        end
    end

    assign result.valid            = rsp_valid_reg;
    assign result.started          = rsp_started_reg;
    assign result.playing          = rsp_playing_reg;
    assign result.tone_on          = rsp_tone_reg;
    assign result.pitch_period_us  = rsp_period_reg;
    assign result.note_duration_ms = rsp_dur_reg;
    assign result.finished         = rsp_finished_reg;

    a_start_finish_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid |-> !(result.started && result.finished))
        else $error("started and finished in the same result");

    a_finish_goes_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && result.finished) |-> (!result.playing && !result.tone_on))
        else $error("finished result still reports playback");

    a_idle_is_silent: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && !result.playing) |->
            (result.pitch_period_us == '0 && result.note_duration_ms == '0))
        else $error("idle result carries a note");

    a_start_sets_title: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && started_next) |=> (active_reg != '0 && index_reg == '0))
        else $error("accepted start did not load a title");

    a_stall_holds_result: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid_reg && !result.ready) |=>
            (rsp_valid_reg && $stable(rsp_period_reg) && $stable(rsp_dur_reg)))
        else $error("result changed while stalled");

endmodule

`default_nettype wire
